@@ hw/rtl/line_pixel_generator_top_assert.svh @@
// assertion macros for the line pixel generator checker
// the using module must provide clk and rst
`ifndef LINE_PIXEL_GENERATOR_TOP_ASSERT_SVH
`define LINE_PIXEL_GENERATOR_TOP_ASSERT_SVH

// checked outside reset
`define LPG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset too
`define LPG_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/lpg_pkg.sv @@
// shared types, constants and the axis step function of the line pixel generator
// no dependencies
`default_nettype none

package lpg_pkg;

  localparam int COORD_BITS = 9;
  localparam int ERR_BITS   = COORD_BITS + 1;
  localparam int COLOR_BITS = 16;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ERR_BITS-1:0]   err_t;
  typedef logic [COLOR_BITS-1:0] color_t;
  typedef logic [1:0]            dir_t;

  localparam dir_t DIR_NONE  = 2'd0;
  localparam dir_t DIR_PLUS  = 2'd1;
  localparam dir_t DIR_MINUS = 2'd3;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
  } lpg_cmd_t;

  typedef struct packed {
    logic last;
  } lpg_sts_t;

  function automatic coord_t axis_move(coord_t pos, dir_t dir);
    coord_t res;
    case (dir)
      DIR_PLUS:  res = pos + coord_t'(1);
      DIR_MINUS: res = pos - coord_t'(1);
      default:   res = pos;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lpg_in_if.sv @@
// input channel: one load or step word with valid/ready
// depends on lpg_pkg
`default_nettype none

interface lpg_in_if
  import lpg_pkg::*;
();
  logic   valid;
  logic   ready;
  logic   mode;
  coord_t x_start;
  coord_t y_start;
  coord_t x_end;
  coord_t y_end;
  color_t pixel_color;

  modport source (output valid, mode, x_start, y_start, x_end, y_end, pixel_color,
                  input ready);
  modport sink   (input valid, mode, x_start, y_start, x_end, y_end, pixel_color,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lpg_out_if.sv @@
// output channel: one pixel word with valid/ready
// depends on lpg_pkg
`default_nettype none

interface lpg_out_if
  import lpg_pkg::*;
();
  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  color_t out_color;
  logic   last_pixel;

  modport source (output valid, pixel_x, pixel_y, out_color, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, out_color, last_pixel, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lpg_ctrl.sv @@
// controller: handshake, line active state, output valid register
// depends on lpg_pkg
`default_nettype none

module lpg_ctrl
  import lpg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     in_mode,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output lpg_cmd_t      cmd,
  input  wire lpg_sts_t sts
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_ACTIVE = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   accept;

  // a word is taken whenever the output register is free or being drained
  assign in_ready = ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;

  always_comb begin
    cmd.load = accept & (in_mode == MODE_LOAD);
    cmd.step = accept & (in_mode == MODE_STEP) & (state == ST_ACTIVE);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.load) state_next = ST_ACTIVE;
      end
      ST_ACTIVE: begin
        if (cmd.step && sts.last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.step) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lpg_datapath.sv @@
// datapath: line setup, error accumulators, position and output payload
// depends on lpg_pkg
`default_nettype none

module lpg_datapath
  import lpg_pkg::*;
(
  input  wire logic     clk,
  input  wire lpg_cmd_t cmd,
  output lpg_sts_t      sts,
  input  wire coord_t   x_start,
  input  wire coord_t   y_start,
  input  wire coord_t   x_end,
  input  wire coord_t   y_end,
  input  wire color_t   pixel_color,
  output coord_t        pixel_x,
  output coord_t        pixel_y,
  output color_t        out_color,
  output logic          last_pixel
);

  coord_t cur_x, cur_y, span_x, span_y, major_len;
  err_t   err_x, err_y, points_left;
  dir_t   dir_x, dir_y;
  color_t line_color;

  coord_t span_x_next, span_y_next, major_next;
  dir_t   dir_x_next, dir_y_next;
  err_t   sum_x, sum_y, err_x_next, err_y_next;
  coord_t cur_x_next, cur_y_next;
  logic   last;

  // setup of both axes from their endpoints, and the major length
  always_comb begin
    if (x_end > x_start) begin
      span_x_next = x_end - x_start;
      dir_x_next  = DIR_PLUS;
    end else if (x_end < x_start) begin
      span_x_next = x_start - x_end;
      dir_x_next  = DIR_MINUS;
    end else begin
      span_x_next = '0;
      dir_x_next  = DIR_NONE;
    end
    if (y_end > y_start) begin
      span_y_next = y_end - y_start;
      dir_y_next  = DIR_PLUS;
    end else if (y_end < y_start) begin
      span_y_next = y_start - y_end;
      dir_y_next  = DIR_MINUS;
    end else begin
      span_y_next = '0;
      dir_y_next  = DIR_NONE;
    end
    major_next = (span_x_next > span_y_next) ? span_x_next : span_y_next;
  end

  // one step of both accumulators
  always_comb begin
    sum_x      = err_x + {1'b0, span_x};
    sum_y      = err_y + {1'b0, span_y};
    err_x_next = sum_x;
    err_y_next = sum_y;
    cur_x_next = cur_x;
    cur_y_next = cur_y;
    if (sum_x >= {1'b0, major_len}) begin
      err_x_next = sum_x - {1'b0, major_len};
      cur_x_next = axis_move(cur_x, dir_x);
    end
    if (sum_y >= {1'b0, major_len}) begin
      err_y_next = sum_y - {1'b0, major_len};
      cur_y_next = axis_move(cur_y, dir_y);
    end
  end

  assign last     = (points_left <= err_t'(1));
  assign sts.last = last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      span_x      <= span_x_next;
      span_y      <= span_y_next;
      dir_x       <= dir_x_next;
      dir_y       <= dir_y_next;
      major_len   <= major_next;
      points_left <= {1'b0, major_next} + err_t'(1);
      cur_x       <= x_start;
      cur_y       <= y_start;
      err_x       <= '0;
      err_y       <= '0;
      line_color  <= pixel_color;
    end else if (cmd.step) begin
      pixel_x     <= cur_x;
      pixel_y     <= cur_y;
      out_color   <= line_color;
      last_pixel  <= last;
      err_x       <= err_x_next;
      err_y       <= err_y_next;
      cur_x       <= cur_x_next;
      cur_y       <= cur_y_next;
      points_left <= last ? '0 : points_left - err_t'(1);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/line_pixel_generator_top.sv @@
// Line pixel generator. A load word (mode 0) sets up a line between two
// endpoints with one color and produces no output; each step word (mode 1)
// then yields one pixel, start point first and end point last, flagged by
// last_pixel; a line of major length n gives n+1 pixels and a step with no
// line loaded is dropped. The block takes one word per clock for as long
// as the single output register is drained; while a pixel waits in that
// register ready stays low.
// depends on lpg_pkg, lpg_in_if, lpg_out_if, lpg_ctrl, lpg_datapath
`default_nettype none

module line_pixel_generator_top
  import lpg_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  lpg_in_if.sink   in_ch,
  lpg_out_if.source out_ch
);

  lpg_cmd_t cmd;
  lpg_sts_t sts;
  logic     in_ready;
  logic     out_valid;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  lpg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  lpg_datapath u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .sts         (sts),
    .x_start     (in_ch.x_start),
    .y_start     (in_ch.y_start),
    .x_end       (in_ch.x_end),
    .y_end       (in_ch.y_end),
    .pixel_color (in_ch.pixel_color),
    .pixel_x     (out_ch.pixel_x),
    .pixel_y     (out_ch.pixel_y),
    .out_color   (out_ch.out_color),
    .last_pixel  (out_ch.last_pixel)
  );

endmodule

`default_nettype wire

@@ hw/rtl/lpg_checker.sv @@
// port-level checks of the line pixel generator, bound to the top level
// depends on lpg_pkg and line_pixel_generator_top_assert.svh
`default_nettype none

`include "line_pixel_generator_top_assert.svh"

module lpg_checker
  import lpg_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst,
  input wire logic   in_valid,
  input wire logic   in_ready,
  input wire logic   in_mode,
  input wire logic   out_valid,
  input wire logic   out_ready,
  input wire coord_t pixel_x,
  input wire coord_t pixel_y,
  input wire color_t out_color,
  input wire logic   last_pixel
);

  logic stalled;
  logic load_taken;
  logic [2*COORD_BITS+COLOR_BITS:0] payload;

  assign stalled    = out_valid & ~out_ready;
  assign load_taken = in_valid & in_ready & (in_mode == MODE_LOAD);
  assign payload    = {pixel_x, pixel_y, out_color, last_pixel};

  `LPG_ASSERT_RST(a_reset_clears_out, rst |=> !out_valid, "output valid after reset")
  `LPG_ASSERT(a_hold_valid, stalled |=> out_valid, "output word dropped under stall")
  `LPG_ASSERT(a_hold_data, stalled |=> $stable(payload), "output word changed under stall")
  `LPG_ASSERT(a_load_no_pixel, load_taken |=> !out_valid, "load word produced a pixel")
  `LPG_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input blocked with empty output")

endmodule

bind line_pixel_generator_top lpg_checker u_lpg_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_mode    (in_ch.mode),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .pixel_x    (out_ch.pixel_x),
  .pixel_y    (out_ch.pixel_y),
  .out_color  (out_ch.out_color),
  .last_pixel (out_ch.last_pixel)
);

`default_nettype wire
